FILE: rtl/tpl_pkg.sv
// Shared types, codes and constants of the serial bus link engine.
// Used by tpl_ctrl, tpl_dpath and the top level; depends on nothing.
package tpl_pkg;

    localparam int HOLD_SLOTS_DEF   = 5;
    localparam int MAX_TELEGRAM_DEF = 512;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 9;
    localparam int SVC_W  = 4;

    localparam logic [LEN_W-1:0] LEN_OFFSET = 9'd9;

    // Transceiver byte classification.
    localparam logic [7:0] MASK_START  = 8'hD3;
    localparam logic [7:0] START_STD   = 8'h81;
    localparam logic [7:0] START_EXT   = 8'h10;
    localparam logic [7:0] MASK_CONF   = 8'h7F;
    localparam logic [7:0] CODE_CONF   = 8'h0B;
    localparam logic [7:0] BYTE_POLL   = 8'hF0;
    localparam logic [7:0] MASK_ACK    = 8'h33;
    localparam logic [7:0] BYTE_RESET  = 8'h03;
    localparam logic [7:0] MASK_STATE  = 8'h07;
    localparam logic [7:0] MASK_FSTATE = 8'h17;
    localparam logic [7:0] CODE_FSTATE = 8'h13;
    localparam logic [7:0] MASK_CFG    = 8'h83;
    localparam logic [7:0] CODE_CFG    = 8'h01;
    localparam logic [7:0] BYTE_END    = 8'hCB;
    localparam logic [7:0] BYTE_STOP   = 8'h2B;
    localparam logic [7:0] BYTE_SYS    = 8'h4B;
    localparam logic [7:0] HIGH_NIB    = 8'hF0;
    localparam logic [7:0] LOW_NIB     = 8'h0F;

    // Line command bytes.
    localparam logic [7:0] LINE_ACK  = 8'h11;
    localparam logic [7:0] TX_START  = 8'h08;
    localparam logic [7:0] TX_CONT   = 8'h80;
    localparam logic [7:0] TX_END    = 8'h47;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_OWN    = 1'b1;

    localparam logic [SVC_W-1:0] SVC_POLL   = 4'd0;
    localparam logic [SVC_W-1:0] SVC_ACK    = 4'd1;
    localparam logic [SVC_W-1:0] SVC_RESET  = 4'd2;
    localparam logic [SVC_W-1:0] SVC_STATE  = 4'd3;
    localparam logic [SVC_W-1:0] SVC_FSTATE = 4'd4;
    localparam logic [SVC_W-1:0] SVC_CONFIG = 4'd5;
    localparam logic [SVC_W-1:0] SVC_END    = 4'd6;
    localparam logic [SVC_W-1:0] SVC_STOP   = 4'd7;
    localparam logic [SVC_W-1:0] SVC_SYSTEM = 4'd8;
    localparam logic [SVC_W-1:0] SVC_UNEXP  = 4'd9;
    localparam logic [SVC_W-1:0] SVC_STRAY  = 4'd10;

    typedef enum logic [1:0] {
        OP_LINE = 2'd0,
        OP_TX   = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_LINE    = 3'd0,
        KIND_RELEASE = 3'd1,
        KIND_CONFIRM = 3'd2,
        KIND_IND     = 3'd3,
        KIND_READ    = 3'd4,
        KIND_DROP    = 3'd5
    } t_kind;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_STD  = 6'b000010,
        PH_EXT  = 6'b000100,
        PH_BODY = 6'b001000,
        PH_CONF = 6'b010000,
        PH_SYS  = 6'b100000
    } t_phase;

    // Source that loads the output register.
    typedef enum logic [3:0] {
        SRC_NONE  = 4'd0,
        SRC_RX    = 4'd1,
        SRC_TX0   = 4'd2,
        SRC_TX1   = 4'd3,
        SRC_TX2   = 4'd4,
        SRC_DROP  = 4'd5,
        SRC_REL   = 4'd6,
        SRC_ACK   = 4'd7,
        SRC_READ  = 4'd8,
        SRC_EMPTY = 4'd9
    } t_src;

    // Telegram memory read address select.
    typedef enum logic [2:0] {
        RD_NONE   = 3'd0,
        RD_RX_IDX = 3'd1,
        RD_REL4   = 3'd2,
        RD_REL5   = 3'd3,
        RD_READ   = 3'd4
    } t_rd;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  data;
        logic [LEN_W-1:0]   len;
        logic               succ;
        logic [SVC_W-1:0]   svc;
        logic               last;
    } t_res;

    typedef struct packed {
        logic capture;
        logic tx_write;
        logic rx_step;
        logic fix_write;
        logic cmp_start;
        logic idx_inc;
        logic set_conf;
        logic hold_start;
        logic copy_write;
        logic rel_clear;
        logic rel_sel;
        t_rd  rd;
        t_src src;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic enable;
        logic pending;
        logic tx_full;
        logic rel_avail;
        logic rx_res;
        logic rx_fix;
        logic rx_done;
        logic len_eq;
        logic bytes_eq;
        logic idx_last;
        logic free_found;
        logic ack;
        logic rel_final;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/tpl_ctrl.sv
// Sequencing state machine of the link engine.
// Depends on tpl_pkg; drives tpl_dpath through a command struct.
module tpl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  tpl_pkg::t_stat i_stat,
    output tpl_pkg::t_cmd  o_cmd
);
    import tpl_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE      = 21'h000001,
        S_DISP      = 21'h000002,
        S_RX        = 21'h000004,
        S_FIX       = 21'h000008,
        S_DONE      = 21'h000010,
        S_HOLD      = 21'h000020,
        S_CMP_RD    = 21'h000040,
        S_CMP_CHK   = 21'h000080,
        S_COPY_RD   = 21'h000100,
        S_COPY_WR   = 21'h000200,
        S_DROP      = 21'h000400,
        S_REL_SEL   = 21'h000800,
        S_REL_RD4   = 21'h001000,
        S_REL_RD5   = 21'h002000,
        S_REL_EMIT  = 21'h004000,
        S_ACK       = 21'h008000,
        S_TX0       = 21'h010000,
        S_TX1       = 21'h020000,
        S_TX2       = 21'h040000,
        S_READ      = 21'h080000,
        S_READ_EMIT = 21'h100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_stat.enable) begin
                    n_state = S_IDLE;
                end else begin
                    case (i_stat.op)
                        OP_LINE: n_state = S_RX;
                        OP_TX: begin
                            if (!i_stat.pending && !i_stat.tx_full) begin
                                o_cmd.tx_write = 1'b1;
                                n_state = S_TX0;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                        OP_READ: n_state = S_READ;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RX: begin
                if (!i_stat.rx_res || i_stat.out_free) begin
                    o_cmd.rx_step = 1'b1;
                    if (i_stat.rx_res) begin
                        o_cmd.src = SRC_RX;
                    end
                    if (i_stat.rx_fix) begin
                        n_state = S_FIX;
                    end else if (i_stat.rx_done) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FIX: begin
                o_cmd.fix_write = 1'b1;
                n_state = S_IDLE;
            end
            S_DONE: begin
                if (i_stat.pending) begin
                    if (i_stat.len_eq) begin
                        o_cmd.cmp_start = 1'b1;
                        n_state = S_CMP_RD;
                    end else begin
                        n_state = S_HOLD;
                    end
                end else begin
                    o_cmd.rel_clear = 1'b1;
                    n_state = S_REL_SEL;
                end
            end
            S_CMP_RD: begin
                o_cmd.rd = RD_RX_IDX;
                n_state = S_CMP_CHK;
            end
            S_CMP_CHK: begin
                if (!i_stat.bytes_eq) begin
                    n_state = S_HOLD;
                end else if (i_stat.idx_last) begin
                    o_cmd.set_conf = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_CMP_RD;
                end
            end
            S_HOLD: begin
                if (i_stat.free_found) begin
                    o_cmd.hold_start = 1'b1;
                    n_state = S_COPY_RD;
                end else begin
                    n_state = S_DROP;
                end
            end
            S_COPY_RD: begin
                o_cmd.rd = RD_RX_IDX;
                n_state = S_COPY_WR;
            end
            S_COPY_WR: begin
                o_cmd.copy_write = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_COPY_RD;
                end
            end
            S_DROP: begin
                if (i_stat.out_free) begin
                    o_cmd.src = SRC_DROP;
                    n_state = S_IDLE;
                end
            end
            S_REL_SEL: begin
                o_cmd.rel_sel = 1'b1;
                n_state = S_REL_RD4;
            end
            S_REL_RD4: begin
                o_cmd.rd = RD_REL4;
                n_state = S_REL_RD5;
            end
            S_REL_RD5: begin
                o_cmd.rd = RD_REL5;
                n_state = S_REL_EMIT;
            end
            S_REL_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.src = SRC_REL;
                    if (i_stat.ack) begin
                        n_state = S_ACK;
                    end else if (i_stat.rel_final) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_REL_SEL;
                    end
                end
            end
            S_ACK: begin
                if (i_stat.out_free) begin
                    o_cmd.src = SRC_ACK;
                    n_state = i_stat.rel_final ? S_IDLE : S_REL_SEL;
                end
            end
            S_TX0: begin
                if (i_stat.out_free) begin
                    o_cmd.src = SRC_TX0;
                    n_state = S_TX1;
                end
            end
            S_TX1: begin
                if (i_stat.out_free) begin
                    o_cmd.src = SRC_TX1;
                    n_state = S_TX2;
                end
            end
            S_TX2: begin
                if (i_stat.out_free) begin
                    o_cmd.src = SRC_TX2;
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (i_stat.rel_avail) begin
                    o_cmd.rd = RD_READ;
                    n_state = S_READ_EMIT;
                end else if (i_stat.out_free) begin
                    o_cmd.src = SRC_EMPTY;
                    n_state = S_IDLE;
                end
            end
            S_READ_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.src = SRC_READ;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/tpl_dpath.sv
// Datapath of the link engine: configuration, receive state, telegram and
// transmit memories, hold slots, release list and the output register.
// Depends on tpl_pkg; commanded by tpl_ctrl.
module tpl_dpath #(
    parameter int HOLD_SLOTS   = tpl_pkg::HOLD_SLOTS_DEF,
    parameter int MAX_TELEGRAM = tpl_pkg::MAX_TELEGRAM_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_op,
    input  logic [7:0]     i_byte,
    input  logic           i_tl,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_m_tready,
    input  tpl_pkg::t_cmd  i_cmd,
    output tpl_pkg::t_stat o_stat,
    output tpl_pkg::t_res  o_out,
    output logic           o_out_valid
);
    import tpl_pkg::*;

    localparam int SLOTS = HOLD_SLOTS + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int HW    = (HOLD_SLOTS > 1) ? $clog2(HOLD_SLOTS) : 1;
    localparam int PW    = $clog2(MAX_TELEGRAM);
    localparam int TLW   = $clog2(MAX_TELEGRAM + 1);
    localparam int AW    = $clog2(SLOTS * MAX_TELEGRAM);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam logic [AW-1:0] RX_BASE = AW'(HOLD_SLOTS * MAX_TELEGRAM);

    logic              r_enable;
    logic [15:0]       r_own;
    t_op               r_op;
    logic [7:0]        r_byte;
    logic              r_tl;
    t_phase            r_phase;
    logic [LEN_W-1:0]  r_cnt;
    logic [LEN_W-1:0]  r_exp;
    logic [LEN_W-1:0]  r_done_len;
    logic [LEN_W-1:0]  r_slot_len [HOLD_SLOTS];
    logic [TLW-1:0]    r_tx_len;
    logic              r_pending;
    logic [PW-1:0]     r_tx_idx;
    logic [LEN_W-1:0]  r_idx;
    logic [HW-1:0]     r_hold_slot;
    logic [CW-1:0]     r_rel_count;
    logic [CW-1:0]     r_rel_index;
    logic [SW-1:0]     r_rel_slot [SLOTS];
    logic [LEN_W-1:0]  r_rel_len [SLOTS];
    logic [PW-1:0]     r_rptr;
    logic [SW-1:0]     r_k;
    logic [SW-1:0]     r_cur_slot;
    logic [LEN_W-1:0]  r_cur_len;
    logic              r_cur_final;
    logic [7:0]        r_dest_hi;
    logic [7:0]        r_rdata;
    logic [7:0]        r_tx_rdata;
    t_res              r_out;
    logic              r_out_valid;
    logic [7:0]        r_tel_mem [SLOTS * MAX_TELEGRAM];
    logic [7:0]        r_tx_mem [MAX_TELEGRAM];

    // Receive step decode.
    logic              rx_wr;
    logic [LEN_W-1:0]  rx_wr_idx;
    logic [7:0]        rx_wr_data;
    t_phase            n_phase;
    logic [LEN_W-1:0]  n_cnt;
    logic [LEN_W-1:0]  n_exp;
    logic              rx_res;
    t_res              rx_out;
    logic              rx_fix;
    logic              rx_done;
    logic              rx_confirm;

    logic              free_found;
    logic [HW-1:0]     free_slot;
    logic              k_valid;
    logic              ack;
    logic              read_end;
    logic [SW-1:0]     rd_slot;
    logic [LEN_W-1:0]  rd_len;
    logic              tel_we;
    logic [AW-1:0]     tel_wa;
    logic [7:0]        tel_wd;
    logic [AW-1:0]     tel_ra;
    logic [AW-1:0]     cur_base;
    t_res              n_out;
    logic              load;

    always_comb begin
        rx_wr      = 1'b0;
        rx_wr_idx  = r_cnt;
        rx_wr_data = r_byte;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_exp      = r_exp;
        rx_res     = 1'b0;
        rx_out     = '0;
        rx_out.kind = KIND_IND;
        rx_out.data = r_byte;
        rx_out.last = 1'b1;
        rx_fix     = 1'b0;
        rx_done    = 1'b0;
        rx_confirm = 1'b0;
        case (r_phase)
            PH_STD: begin
                rx_wr = 1'b1;
                if (r_cnt >= 9'd6) begin
                    // Control field splits: low nibble lands in byte 6 now,
                    // high nibble in byte 1 on the following cycle.
                    rx_wr_idx  = 9'd6;
                    rx_wr_data = r_byte & LOW_NIB;
                    rx_fix     = 1'b1;
                    n_exp      = {5'd0, r_byte[3:0]} + LEN_OFFSET;
                    n_cnt      = 9'd7;
                    n_phase    = PH_BODY;
                end else begin
                    n_cnt = r_cnt + 9'd1;
                end
            end
            PH_EXT: begin
                rx_wr = 1'b1;
                if (r_cnt >= 9'd6) begin
                    n_exp   = {1'b0, r_byte} + LEN_OFFSET;
                    n_phase = PH_BODY;
                end
                n_cnt = r_cnt + 9'd1;
            end
            PH_BODY: begin
                rx_wr = 1'b1;
                n_cnt = r_cnt + 9'd1;
                if ((r_cnt + 9'd1) >= r_exp) begin
                    n_phase = PH_IDLE;
                    rx_done = 1'b1;
                end
            end
            PH_CONF: begin
                n_phase     = PH_IDLE;
                rx_res      = 1'b1;
                rx_confirm  = 1'b1;
                rx_out.kind = KIND_CONFIRM;
                rx_out.data = 8'd0;
                rx_out.succ = |r_byte[6:0];
            end
            PH_SYS: begin
                n_phase    = PH_IDLE;
                rx_res     = 1'b1;
                rx_out.svc = SVC_SYSTEM;
            end
            default: begin
                n_phase = PH_IDLE;
                rx_res  = 1'b1;
                if ((r_byte & MASK_START) == START_STD) begin
                    rx_wr     = 1'b1;
                    rx_wr_idx = 9'd0;
                    n_cnt     = 9'd2;
                    n_phase   = PH_STD;
                    rx_res    = 1'b0;
                end else if ((r_byte & MASK_START) == START_EXT) begin
                    rx_wr     = 1'b1;
                    rx_wr_idx = 9'd0;
                    n_cnt     = 9'd1;
                    n_phase   = PH_EXT;
                    rx_res    = 1'b0;
                end else if ((r_byte & MASK_CONF) == CODE_CONF) begin
                    if (r_pending) begin
                        rx_confirm  = 1'b1;
                        rx_out.kind = KIND_CONFIRM;
                        rx_out.data = 8'd0;
                        rx_out.succ = r_byte[7];
                    end else begin
                        rx_out.svc = SVC_STRAY;
                    end
                end else if (r_byte == BYTE_POLL) begin
                    rx_out.svc = SVC_POLL;
                end else if ((r_byte & MASK_ACK) == 8'd0) begin
                    rx_out.svc = SVC_ACK;
                end else if (r_byte == BYTE_RESET) begin
                    rx_out.svc = SVC_RESET;
                end else if ((r_byte & MASK_STATE) == MASK_STATE) begin
                    rx_out.svc = SVC_STATE;
                end else if ((r_byte & MASK_FSTATE) == CODE_FSTATE) begin
                    rx_out.svc = SVC_FSTATE;
                end else if ((r_byte & MASK_CFG) == CODE_CFG) begin
                    rx_out.svc = SVC_CONFIG;
                end else if (r_byte == BYTE_END) begin
                    rx_out.svc = SVC_END;
                end else if (r_byte == BYTE_STOP) begin
                    rx_out.svc = SVC_STOP;
                end else if (r_byte == BYTE_SYS) begin
                    n_phase = PH_SYS;
                    rx_res  = 1'b0;
                end else begin
                    rx_out.svc = SVC_UNEXP;
                end
            end
        endcase
    end

    // First free hold slot.
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = HOLD_SLOTS - 1; i >= 0; i--) begin
            if (r_slot_len[i] == '0) begin
                free_found = 1'b1;
                free_slot  = HW'(i);
            end
        end
    end

    assign k_valid  = (r_k < SW'(HOLD_SLOTS)) && (r_slot_len[r_k[HW-1:0]] != '0);
    assign ack      = (r_own == 16'd0) && ({r_dest_hi, r_rdata} == 16'd0);
    assign rd_slot  = r_rel_slot[r_rel_index[SW-1:0]];
    assign rd_len   = r_rel_len[r_rel_index[SW-1:0]];
    assign read_end = ({1'b0, r_rptr} + (PW+1)'(1)) >= (PW+1)'(rd_len);
    assign cur_base = AW'(r_cur_slot) * AW'(MAX_TELEGRAM);

    always_comb begin
        tel_we = 1'b0;
        tel_wa = RX_BASE + AW'(rx_wr_idx);
        tel_wd = rx_wr_data;
        if (i_cmd.rx_step && rx_wr) begin
            tel_we = 1'b1;
        end else if (i_cmd.fix_write) begin
            tel_we = 1'b1;
            tel_wa = RX_BASE + AW'(1);
            tel_wd = r_byte & HIGH_NIB;
        end else if (i_cmd.copy_write) begin
            tel_we = 1'b1;
            tel_wa = AW'(r_hold_slot) * AW'(MAX_TELEGRAM) + AW'(r_idx);
            tel_wd = r_rdata;
        end
    end

    always_comb begin
        case (i_cmd.rd)
            RD_REL4: tel_ra = cur_base + AW'(4);
            RD_REL5: tel_ra = cur_base + AW'(5);
            RD_READ: tel_ra = AW'(rd_slot) * AW'(MAX_TELEGRAM) + AW'(r_rptr);
            default: tel_ra = RX_BASE + AW'(r_idx);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tel_we) begin
            r_tel_mem[tel_wa] <= tel_wd;
        end
        if (i_cmd.rd != RD_NONE) begin
            r_rdata <= r_tel_mem[tel_ra];
        end
        if (i_cmd.tx_write) begin
            r_tx_mem[r_tx_len[PW-1:0]] <= r_byte;
        end
        if (i_cmd.rd == RD_RX_IDX) begin
            r_tx_rdata <= r_tx_mem[PW'(r_idx)];
        end
    end

    always_comb begin
        n_out      = '0;
        n_out.kind = KIND_LINE;
        case (i_cmd.src)
            SRC_RX: n_out = rx_out;
            SRC_TX0: n_out.data = TX_START | 8'(r_tx_idx >> 6);
            SRC_TX1: n_out.data = r_tl ? TX_END : (TX_CONT | {2'b00, r_tx_idx[5:0]});
            SRC_TX2: begin
                n_out.data = r_byte;
                n_out.last = 1'b1;
            end
            SRC_DROP: begin
                n_out.kind = KIND_DROP;
                n_out.len  = r_done_len;
                n_out.last = 1'b1;
            end
            SRC_REL: begin
                n_out.kind = KIND_RELEASE;
                n_out.len  = r_cur_len;
                n_out.last = r_cur_final && !ack;
            end
            SRC_ACK: begin
                n_out.data = LINE_ACK;
                n_out.last = r_cur_final;
            end
            SRC_READ: begin
                n_out.kind = KIND_READ;
                n_out.data = r_rdata;
                n_out.len  = rd_len;
                n_out.succ = 1'b1;
                n_out.last = read_end;
            end
            SRC_EMPTY: begin
                n_out.kind = KIND_READ;
                n_out.last = 1'b1;
            end
            default: n_out = '0;
        endcase
    end

    assign load = (i_cmd.src != SRC_NONE);

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_op);
            r_byte <= i_byte;
            r_tl   <= i_tl;
        end
        if (load) begin
            r_out <= n_out;
        end
        if (i_cmd.rx_step && rx_done) begin
            r_done_len <= r_exp;
        end
        if (i_cmd.tx_write) begin
            r_tx_idx <= r_tx_len[PW-1:0];
        end
        if (i_cmd.cmp_start) begin
            r_idx <= '0;
        end else if (i_cmd.hold_start) begin
            r_idx       <= '0;
            r_hold_slot <= free_slot;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 9'd1;
        end
        if (i_cmd.rel_sel) begin
            r_cur_slot  <= k_valid ? r_k : SW'(HOLD_SLOTS);
            r_cur_len   <= k_valid ? r_slot_len[r_k[HW-1:0]] : r_done_len;
            r_cur_final <= !k_valid;
        end
        if (i_cmd.rd == RD_REL5) begin
            r_dest_hi <= r_rdata;
        end
        if ((i_cmd.src == SRC_REL) && (r_rel_count < CW'(SLOTS))) begin
            r_rel_slot[r_rel_count[SW-1:0]] <= r_cur_slot;
            r_rel_len[r_rel_count[SW-1:0]]  <= r_cur_len;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_own       <= 16'd0;
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_exp       <= '0;
            r_tx_len    <= '0;
            r_pending   <= 1'b0;
            r_rel_count <= '0;
            r_rel_index <= '0;
            r_rptr      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < HOLD_SLOTS; i++) begin
                r_slot_len[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    CFG_OWN:    r_own    <= i_cfg_data;
                    default:    r_enable <= r_enable;
                endcase
            end
            if (i_cmd.rx_step) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_exp   <= n_exp;
            end else if (i_cmd.set_conf) begin
                r_phase <= PH_CONF;
            end
            if (i_cmd.rx_step && rx_confirm) begin
                r_pending <= 1'b0;
                r_tx_len  <= '0;
            end else if (i_cmd.tx_write) begin
                r_tx_len <= r_tx_len + TLW'(1);
                if (r_tl) begin
                    r_pending <= 1'b1;
                end
            end
            if (i_cmd.copy_write && ((r_idx + 9'd1) == r_done_len)) begin
                r_slot_len[r_hold_slot] <= r_done_len;
            end
            if (i_cmd.rel_clear) begin
                r_rel_count <= '0;
                r_rel_index <= '0;
                r_rptr      <= '0;
                r_k         <= '0;
            end else if (i_cmd.src == SRC_REL) begin
                if (r_rel_count < CW'(SLOTS)) begin
                    r_rel_count <= r_rel_count + CW'(1);
                end
                if (!r_cur_final) begin
                    r_slot_len[r_cur_slot[HW-1:0]] <= '0;
                    r_k <= r_k + SW'(1);
                end
            end else if (i_cmd.src == SRC_READ) begin
                if (read_end) begin
                    r_rel_index <= r_rel_index + CW'(1);
                    r_rptr      <= '0;
                end else begin
                    r_rptr <= r_rptr + PW'(1);
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.enable     = r_enable;
        o_stat.pending    = r_pending;
        o_stat.tx_full    = (r_tx_len >= TLW'(MAX_TELEGRAM));
        o_stat.rel_avail  = (r_rel_index < r_rel_count);
        o_stat.rx_res     = rx_res;
        o_stat.rx_fix     = rx_fix;
        o_stat.rx_done    = rx_done;
        o_stat.len_eq     = (TLW'(r_done_len) == r_tx_len);
        o_stat.bytes_eq   = (r_rdata == r_tx_rdata);
        o_stat.idx_last   = ((r_idx + 9'd1) == r_done_len);
        o_stat.free_found = free_found;
        o_stat.ack        = ack;
        o_stat.rel_final  = r_cur_final;
        o_stat.out_free   = !r_out_valid || i_m_tready;
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/knx_tpuart_link_engine_core.sv
// Top level of the serial bus transceiver link engine (host side).
// Instantiates tpl_ctrl and tpl_dpath; depends on tpl_pkg.
//
// Usage: the slave stream takes one word per item: tuser is the opcode
// (transceiver byte, host transmit byte, host read), tdata the byte, and
// tlast marks the final byte of a transmit telegram. The master stream
// gives zero to several result words per item; tuser carries the result
// kind and tlast marks the last word of an item (or, for read data, the
// last byte of a telegram). Configuration register 0 is enable, 1 the own address.
// Throughput: one item at a time. A transceiver byte passes dispatch and the
// receive step (and a fix-up write for a standard control field), a transmit
// byte dispatch and three line words, a read dispatch and one result word. A
// telegram end adds a done step, then the echo compare (read and check per
// byte), a copy into a hold slot (read and write per byte through the single
// telegram memory port), or per released telegram a select, two destination reads,
// the release word and any acknowledge; each word needs a free output register.
// Reset clears all control state; the memories need no clearing. When the
// receiver stalls, the result waits in the output register and the engine
// holds in its current step, but a new item is still taken while the last
// result of the previous one waits.
module knx_tpuart_link_engine_core #(
    parameter int HOLD_SLOTS   = tpl_pkg::HOLD_SLOTS_DEF,
    parameter int MAX_TELEGRAM = tpl_pkg::MAX_TELEGRAM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_tuser,   // [1:0] opcode
    input  logic        i_s_tlast,   // tx_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] out_byte, [16:8] frame_length,
                                     // [17] success, [21:18] service, zero pad
    output logic [2:0]  o_m_tuser,   // [2:0] kind
    output logic        o_m_tlast,   // last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import tpl_pkg::*;

    t_cmd w_cmd;
    t_stat w_stat;
    t_res w_out;

    tpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tpl_dpath #(
        .HOLD_SLOTS   (HOLD_SLOTS),
        .MAX_TELEGRAM (MAX_TELEGRAM)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (i_s_tuser),
        .i_byte      (i_s_tdata),
        .i_tl        (i_s_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out       (w_out),
        .o_out_valid (o_m_tvalid)
    );

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    assign o_m_tdata = {2'b00, w_out.svc, w_out.succ, w_out.len, w_out.data};
    assign o_m_tuser = w_out.kind;
    assign o_m_tlast = w_out.last;

    // One item in work at a time: the word after an accepted one waits.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item was still in work");

    // Confirm, indication and drop words always close their item.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == KIND_CONFIRM || o_m_tuser == KIND_IND
            || o_m_tuser == KIND_DROP)) |-> o_m_tlast)
        else $error("single-word result without last flag");

    // The sequencer only loads the output register when it is free.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.src != SRC_NONE) |-> w_stat.out_free)
        else $error("output register overwritten while full");

endmodule

FILE: tb/knx_tpuart_link_engine_core_tb.sv
// Self-checking testbench for the serial bus link engine top level.
// Holds its own predictor of the engine in a small scoreboard class; depends on tpl_pkg.
`timescale 1ns / 100ps

module knx_tpuart_link_engine_core_tb;
    import tpl_pkg::*;

    localparam int SLOTS     = HOLD_SLOTS_DEF + 1;
    localparam int RX_SLOT   = HOLD_SLOTS_DEF;
    localparam int TEL_MAX   = MAX_TELEGRAM_DEF;
    localparam int LIMIT     = 600000;
    localparam int SETTLE    = 1500;
    localparam int ITEMS     = 400;

    // Mirror of the engine: predicts the result words that each accepted item causes.
    class link_scoreboard;
        bit          en;
        bit [15:0]   own;
        t_phase      phase;
        int          rx_cnt, rx_exp;
        bit [7:0]    tel_mem[SLOTS*TEL_MAX];
        int          slot_len[SLOTS];
        bit [7:0]    tx_mem[TEL_MAX];
        int          tx_len;
        bit          pending;
        int          rd_ptr, rel_cnt, rel_idx;
        int          rel_slot[SLOTS], rel_len[SLOTS];
        t_res        pending_words[$];
        int          errors;

        function new();
            en = 0; own = 0; phase = PH_IDLE; rx_cnt = 0; rx_exp = 0;
            tx_len = 0; pending = 0; rd_ptr = 0; rel_cnt = 0; rel_idx = 0;
            errors = 0;
            foreach (slot_len[i]) slot_len[i] = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void push(t_kind k, bit [7:0] b, int len, bit s, bit [3:0] svc);
            t_res r;
            r.kind = k; r.data = b; r.len = len[8:0]; r.succ = s; r.svc = svc; r.last = 0;
            pending_words.push_back(r);
        endfunction

        function void config_write(logic idx, logic [15:0] v);
            if (idx == CFG_ENABLE) en = v[0];
            else own = v;
        endfunction

        function void release_slot(int s, int len);
            int base;
            base = s * TEL_MAX;
            if (rel_cnt < SLOTS) begin
                rel_slot[rel_cnt] = s;
                rel_len[rel_cnt] = len;
                rel_cnt++;
            end
            push(KIND_RELEASE, 8'h00, len, 0, 4'd0);
            if (own == 0 && tel_mem[base+4] == 0 && tel_mem[base+5] == 0)
                push(KIND_LINE, LINE_ACK, 0, 0, 4'd0);
        endfunction

        function void telegram_end(int len);
            bit diff;
            int rx;
            rx = RX_SLOT * TEL_MAX;
            if (pending) begin
                diff = (len != tx_len);
                for (int i = 0; !diff && i < len; i++)
                    if (tel_mem[rx+i] != tx_mem[i]) diff = 1;
                if (!diff) begin
                    phase = PH_CONF;
                    return;
                end
                // Not the echo: park it in a free hold slot, or drop it.
                for (int i = 0; i < HOLD_SLOTS_DEF; i++) begin
                    if (slot_len[i] != 0) continue;
                    for (int j = 0; j < len; j++) tel_mem[i*TEL_MAX+j] = tel_mem[rx+j];
                    slot_len[i] = len;
                    return;
                end
                push(KIND_DROP, 8'h00, len, 0, 4'd0);
                return;
            end
            rel_cnt = 0; rel_idx = 0; rd_ptr = 0;
            for (int i = 0; i < HOLD_SLOTS_DEF && slot_len[i] != 0; i++) begin
                release_slot(i, slot_len[i]);
                slot_len[i] = 0;
            end
            release_slot(RX_SLOT, len);
        endfunction

        function void classify(bit [7:0] b);
            int rx;
            rx = RX_SLOT * TEL_MAX;
            if ((b & MASK_START) == START_STD || (b & MASK_START) == START_EXT) begin
                tel_mem[rx] = b;
                if ((b & MASK_START) == START_STD) begin
                    rx_cnt = 2; phase = PH_STD;
                end else begin
                    rx_cnt = 1; phase = PH_EXT;
                end
            end else if ((b & MASK_CONF) == CODE_CONF) begin
                if (!pending) push(KIND_IND, b, 0, 0, SVC_STRAY);
                else begin
                    pending = 0; tx_len = 0;
                    push(KIND_CONFIRM, 8'h00, 0, b[7], 4'd0);
                end
            end
            else if (b == BYTE_POLL)                   push(KIND_IND, b, 0, 0, SVC_POLL);
            else if ((b & MASK_ACK) == 8'h00)          push(KIND_IND, b, 0, 0, SVC_ACK);
            else if (b == BYTE_RESET)                  push(KIND_IND, b, 0, 0, SVC_RESET);
            else if ((b & MASK_STATE) == MASK_STATE)   push(KIND_IND, b, 0, 0, SVC_STATE);
            else if ((b & MASK_FSTATE) == CODE_FSTATE) push(KIND_IND, b, 0, 0, SVC_FSTATE);
            else if ((b & MASK_CFG) == CODE_CFG)       push(KIND_IND, b, 0, 0, SVC_CONFIG);
            else if (b == BYTE_END)                    push(KIND_IND, b, 0, 0, SVC_END);
            else if (b == BYTE_STOP)                   push(KIND_IND, b, 0, 0, SVC_STOP);
            else if (b == BYTE_SYS)                    phase = PH_SYS;
            else                                       push(KIND_IND, b, 0, 0, SVC_UNEXP);
        endfunction

        function void line_byte(bit [7:0] b);
            int rx;
            rx = RX_SLOT * TEL_MAX;
            case (phase)
                PH_STD: begin
                    if (rx_cnt >= 6) begin
                        tel_mem[rx+1] = b & HIGH_NIB;
                        tel_mem[rx+6] = b & LOW_NIB;
                        rx_exp = int'(b[3:0]) + 9;
                        rx_cnt = 7;
                        phase = PH_BODY;
                    end else begin
                        tel_mem[rx+rx_cnt] = b;
                        rx_cnt++;
                    end
                end
                PH_EXT: begin
                    if (rx_cnt < TEL_MAX) tel_mem[rx+rx_cnt] = b;
                    if (rx_cnt >= 6) begin
                        rx_exp = int'(b) + 9;
                        phase = PH_BODY;
                    end
                    rx_cnt++;
                end
                PH_BODY: begin
                    if (rx_cnt < TEL_MAX) tel_mem[rx+rx_cnt] = b;
                    rx_cnt++;
                    if (rx_cnt >= rx_exp) begin
                        phase = PH_IDLE;
                        telegram_end(rx_exp);
                    end
                end
                PH_CONF: begin
                    phase = PH_IDLE; pending = 0; tx_len = 0;
                    push(KIND_CONFIRM, 8'h00, 0, (b & MASK_CONF) != 0, 4'd0);
                end
                PH_SYS: begin
                    phase = PH_IDLE;
                    push(KIND_IND, b, 0, 0, SVC_SYSTEM);
                end
                default: begin
                    phase = PH_IDLE;
                    classify(b);
                end
            endcase
        endfunction

        // Called once per accepted input word.
        function void note_input(t_op op, bit [7:0] b, bit tl);
            int before_n, s, l, p;
            t_res r;
            if (!en) return;
            before_n = pending_words.size();
            case (op)
                OP_LINE: line_byte(b);
                OP_TX: begin
                    if (!pending && tx_len < TEL_MAX) begin
                        tx_mem[tx_len] = b;
                        push(KIND_LINE, TX_START | 8'(tx_len >> 6), 0, 0, 4'd0);
                        push(KIND_LINE, tl ? TX_END : (TX_CONT | 8'(tx_len & 63)), 0, 0, 4'd0);
                        push(KIND_LINE, b, 0, 0, 4'd0);
                        tx_len++;
                        if (tl) pending = 1;
                    end
                end
                OP_READ: begin
                    if (rel_idx >= rel_cnt) begin
                        r = '0; r.kind = KIND_READ; r.last = 1;
                    end else begin
                        s = rel_slot[rel_idx] % SLOTS;
                        l = rel_len[rel_idx];
                        p = rd_ptr % TEL_MAX;
                        r.kind = KIND_READ; r.data = tel_mem[s*TEL_MAX+p];
                        r.len = l[8:0]; r.succ = 1; r.svc = 0; r.last = (p + 1 >= l);
                        if (r.last) begin
                            rel_idx++; rd_ptr = 0;
                        end else rd_ptr = p + 1;
                    end
                    pending_words.push_back(r);
                    return;
                end
                default: ;
            endcase
            if (pending_words.size() > before_n)
                pending_words[pending_words.size()-1].last = 1;
        endfunction

        task check_result(t_res got);
            t_res w;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word kind %0d data %02h", got.kind, got.data));
                return;
            end
            w = pending_words.pop_front();
            if (got.kind !== w.kind) report($sformatf("kind %0d, want %0d", got.kind, w.kind));
            if (got.data !== w.data) report($sformatf("byte %02h, want %02h", got.data, w.data));
            if (got.len !== w.len) report($sformatf("length %0d, want %0d", got.len, w.len));
            if (got.succ !== w.succ) report($sformatf("success %0b, want %0b", got.succ, w.succ));
            if (got.svc !== w.svc) report($sformatf("service %0d, want %0d", got.svc, w.svc));
            if (got.last !== w.last) report($sformatf("last %0b, want %0b", got.last, w.last));
        endtask
    endclass

    logic        i_clk, i_rst_n;
    logic        i_s_tvalid, o_s_tready;
    logic [7:0]  i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        i_s_tlast;
    logic        o_m_tvalid, i_m_tready;
    logic [23:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid, o_cfg_ready, i_cfg_index;
    logic [15:0] i_cfg_data;

    link_scoreboard sb;
    int  words_sent;
    int  cycles = 0;
    bit  hold_off;

    knx_tpuart_link_engine_core uut (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung engine or handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one word on the input stream and wait until the engine takes it.
    // The valid line only drops when a gap is drawn, so back-to-back words keep it high.
    task send_word(t_op op, bit [7:0] b, bit tl);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= b;
        i_s_tlast  <= tl;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(op, b, tl);
        words_sent++;
    endtask

    task write_reg(logic idx, logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.config_write(idx, v);
        i_cfg_valid <= 1'b0;
    endtask

    // Let the engine drain: all predicted words out, then time for a hold-slot copy
    // that produces no word at all.
    task drain;
        i_s_tvalid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Build a telegram: raw line bytes, and the extended image the engine stores.
    task automatic make_telegram(bit std, int n, bit dest_zero,
                                 output bit [7:0] raw[$], output bit [7:0] img[$]);
        bit [7:0] b;
        raw = {}; img = {};
        if (std) begin
            raw.push_back(START_STD | (8'($urandom) & 8'h2C));
            for (int i = 1; i <= 4; i++)
                raw.push_back((dest_zero && i >= 3) ? 8'h00 : 8'($urandom));
            b = (8'($urandom) & HIGH_NIB) | 8'(n);
            raw.push_back(b);
            img = {raw[0], b & HIGH_NIB, raw[1], raw[2], raw[3], raw[4], b & LOW_NIB};
            for (int i = 0; i < n + 2; i++) begin
                b = 8'($urandom);
                raw.push_back(b);
                img.push_back(b);
            end
        end else begin
            raw.push_back(START_EXT | (8'($urandom) & 8'h2C));
            for (int i = 1; i <= 5; i++)
                raw.push_back((dest_zero && i >= 4) ? 8'h00 : 8'($urandom));
            raw.push_back(8'(n));
            for (int i = 0; i < n + 2; i++) raw.push_back(8'($urandom));
            img = raw;
        end
    endtask

    task send_line(bit [7:0] bytes[$]);
        foreach (bytes[i]) send_word(OP_LINE, bytes[i], 1'($urandom_range(0, 1)));
    endtask

    task send_tx(bit [7:0] bytes[$]);
        foreach (bytes[i]) send_word(OP_TX, bytes[i], i == bytes.size() - 1);
    endtask

    function int pick_len(bit std);
        if (std) return $urandom_range(0, 15);
        if ($urandom_range(0, 19) == 0) return $urandom_range(100, 255);
        return $urandom_range(0, 12);
    endfunction

    // A full send: transmit, maybe foreign telegrams meanwhile, the echo, then the confirm.
    task send_sequence;
        bit [7:0] raw[$], img[$], oraw[$], oimg[$];
        bit std;
        int others;
        std = 1'($urandom_range(0, 1));
        make_telegram(std, pick_len(std), 1'($urandom_range(0, 1)), raw, img);
        send_tx(img);
        others = $urandom_range(0, 7);
        for (int k = 0; k < others; k++) begin
            std = 1'($urandom_range(0, 1));
            make_telegram(std, std ? $urandom_range(0, 15) : $urandom_range(0, 6),
                          1'($urandom_range(0, 1)), oraw, oimg);
            send_line(oraw);
        end
        if ($urandom_range(0, 4) == 0) raw[$urandom_range(1, raw.size() - 1)] ^= 8'h5A;
        send_line(raw);
        send_word(OP_LINE, 8'($urandom), 1'b0);
    endtask

    // Receiver: random stalls per word, plus the long hold-off on request.
    initial begin
        t_res got;
        int gap;
        i_m_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                i_m_tready <= 1'b0;
                while (hold_off) @(posedge i_clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            got.kind = t_kind'(o_m_tuser);
            got.data = o_m_tdata[7:0];
            got.len  = o_m_tdata[16:8];
            got.succ = o_m_tdata[17];
            got.svc  = o_m_tdata[21:18];
            got.last = o_m_tlast;
            sb.check_result(got);
        end
    end

    // Long receiver hold-off, timed here, so the engine backs up and stalls its input.
    initial begin
        hold_off = 0;
        wait (words_sent >= 150);
        hold_off = 1;
        repeat (700) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        bit [7:0] raw[$], img[$];
        bit [7:0] ind_bytes[$];
        bit std;
        int sel;
        sb = new();
        words_sent = 0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= 8'h00;
        i_s_tuser   <= OP_LINE;
        i_s_tlast   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ENABLE;
        i_cfg_data  <= 16'h0000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Disabled engine ignores everything.
        send_word(OP_LINE, 8'hF0, 1'b0);
        send_word(OP_TX, 8'hFF, 1'b1);
        drain();
        write_reg(CFG_OWN, 16'h0000);
        write_reg(CFG_ENABLE, 16'h0001);

        // Directed: every indication class, the status byte pair, a stray confirm,
        // an empty read, unused opcode, then a telegram with acknowledge and reads.
        ind_bytes = {8'hF0, 8'h00, 8'h03, 8'hFF, 8'h13, 8'h01, 8'hCB, 8'h2B, 8'h8A, 8'h0B};
        foreach (ind_bytes[i])
            send_word(OP_LINE, ind_bytes[i], 1'b0);
        send_word(OP_LINE, BYTE_SYS, 1'b0);
        send_word(OP_LINE, 8'hA5, 1'b1);
        send_word(OP_READ, 8'h00, 1'b0);
        send_word(OP_NONE, 8'h55, 1'b1);
        make_telegram(1'b1, 0, 1'b1, raw, img);
        send_line(raw);
        repeat (3) send_word(OP_READ, 8'hFF, 1'b1);
        drain();

        // Random traffic over several register settings.
        for (int ph = 0; words_sent < ITEMS; ph++) begin
            case (ph % 5)
                0: write_reg(CFG_OWN, 16'h0000);
                1: write_reg(CFG_OWN, 16'hFFFF);
                2: write_reg(CFG_OWN, 16'($urandom));
                3: begin
                    write_reg(CFG_ENABLE, 16'h0000);
                    repeat (6) send_word(t_op'($urandom_range(0, 3)), 8'($urandom),
                                         1'($urandom_range(0, 1)));
                    drain();
                    write_reg(CFG_ENABLE, 16'hFFFF);
                end
                default: write_reg(CFG_OWN, 16'h0000);
            endcase
            for (int j = 0; j < 12 && words_sent < ITEMS; j++) begin
                sel = $urandom_range(0, 9);
                if (sel < 3) begin
                    std = 1'($urandom_range(0, 1));
                    make_telegram(std, pick_len(std), 1'($urandom_range(0, 1)), raw, img);
                    send_line(raw);
                end else if (sel < 6) begin
                    send_sequence();
                end else if (sel < 8) begin
                    repeat ($urandom_range(1, 14)) send_word(OP_READ, 8'($urandom),
                                                            1'($urandom_range(0, 1)));
                end else begin
                    repeat ($urandom_range(1, 3))
                        send_word(t_op'($urandom_range(0, 3)), 8'($urandom),
                                  1'($urandom_range(0, 1)));
                end
            end
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: knx_tpuart_link_engine_core.f
rtl/tpl_pkg.sv
rtl/tpl_ctrl.sv
rtl/tpl_dpath.sv
rtl/knx_tpuart_link_engine_core.sv
tb/knx_tpuart_link_engine_core_tb.sv
